// ===== hdl/fgon_pkg.sv =====
// fgon_pkg: shared widths, register indexes, reset values and state codes
// for the frame gain/offset normalizer. No dependencies.

package fgon_pkg;

  // payload field widths
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 5;
  localparam int OFFSET_W = 17;

  // configuration register widths
  localparam int FLEN_W   = 15;
  localparam int PERIOD_W = 8;
  localparam int SPAN_W   = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IW   = 2;

  // width of lengths, counts and spans (frame sizes up to 65536)
  localparam int LEN_W = 17;

  // configuration reset values
  localparam logic [FLEN_W-1:0]   FRAME_LENGTH_RST   = 15'd16000;
  localparam logic [PERIOD_W-1:0] REFRESH_PERIOD_RST = 8'd5;
  localparam logic [SPAN_W-1:0]   TARGET_SPAN_RST    = 16'd18000;
  localparam logic [GAIN_W-1:0]   MAX_GAIN_RST       = 5'd25;

  // configuration register indexes
  typedef enum logic [CFG_IW-1:0] {
    CFG_FRAME_LENGTH   = 2'd0,
    CFG_REFRESH_PERIOD = 2'd1,
    CFG_TARGET_SPAN    = 2'd2,
    CFG_MAX_GAIN       = 2'd3
  } cfg_idx_e;

  // control sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_MEAN_GO,
    ST_MEAN_RUN,
    ST_GAIN_RUN
  } state_e;

endpackage

// ===== hdl/fgon_if.sv =====
// fgon_if: valid/ready stream interfaces for the sample input and the
// normalized output. Depends on fgon_pkg for the field widths.

interface fgon_in_if import fgon_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface fgon_out_if import fgon_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_out;
  logic                       frame_end;
  logic        [GAIN_W-1:0]   gain_used;
  logic signed [OFFSET_W-1:0] offset_used;

  modport source (output valid, output sample_out, output frame_end,
                  output gain_used, output offset_used, input ready);
  modport sink   (input valid, input sample_out, input frame_end,
                  input gain_used, input offset_used, output ready);
endinterface

// ===== hdl/fgon_div.sv =====
// fgon_div: unsigned restoring divider, one quotient bit per cycle.
// Shared for the frame mean and the gain. No package dependencies.

module fgon_div #(
  parameter int DW = 31,
  parameter int VW = 17
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          busy_o,
  output logic          done_o,
  output logic [DW-1:0] quotient_o
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] quo_q;
  logic [VW-1:0] rem_q;
  logic [VW-1:0] dvs_q;

  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;
  logic [VW-1:0] rem_n;

  // trial subtract of the shifted remainder
  always_comb begin
    trial = {rem_q, quo_q[DW-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = (trial >= {1'b0, dvs_q});
    rem_n = ge ? diff[VW-1:0] : trial[VW-1:0];
  end

  // iteration control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // dividend shifts out as the quotient shifts in
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DW-2:0], ge};
      rem_q <= rem_n;
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== hdl/frame_gain_offset_normalizer_top.sv =====
// frame_gain_offset_normalizer_top: frame store, running statistics, output
// scaling and refresh sequencer. Depends on fgon_pkg, fgon_if and fgon_div.
//
// Usage:
//   in_i carries one signed 16-bit sample per beat, out_o one normalized
//   sample of the previous frame per beat, with frame_end, gain and offset.
//   cfg_we_i/cfg_idx_i/cfg_data_i write frame_length, refresh_period,
//   target_span and max_gain; write only while the block is idle.
//   Each accepted sample reads the stored sample at its frame position from
//   the single-port frame memory and writes the new sample back in ST_CALC,
//   which a stalled out_o can delay; no new sample is accepted before it.
//   The first frame gives no output beats; after that, every sample gives
//   one beat, registered into the output when the sample is written back.
//   On the last sample of a refreshing frame the shared divider runs for the
//   mean and then, unless the frame span is zero, for the gain, during which
//   in_i is not ready.
//   When out_o is stalled with a beat waiting, the next sample is accepted
//   and held in the memory read stage until the output register frees.
//   Reset clears the position, frame counter, gain and offset, loads the
//   default configuration and discards any waiting beat; the memory itself
//   is not cleared.

module frame_gain_offset_normalizer_top import fgon_pkg::*; #(
  parameter int FRAME_MAX = 16384
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  fgon_in_if.sink           in_i,
  fgon_out_if.source        out_o,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]  cfg_data_i
);

  localparam int PW    = $clog2(FRAME_MAX);
  localparam int SUM_W = PW + 17;
  localparam int PROD_W = 24;

  // configuration registers
  logic [FLEN_W-1:0]   frame_length_q;
  logic [PERIOD_W-1:0] refresh_period_q;
  logic [SPAN_W-1:0]   target_span_q;
  logic [GAIN_W-1:0]   max_gain_q;

  // control state
  state_e         state_q, state_d;
  logic [PW-1:0]  pos_q;
  logic [PERIOD_W-1:0] phase_q;
  logic           primed_q;
  logic           out_valid_q;

  // datapath registers
  logic signed [SAMPLE_W-1:0] sample_q;
  logic signed [SAMPLE_W-1:0] rdata_q;
  logic signed [SUM_W-1:0]    sum_q;
  logic signed [SAMPLE_W-1:0] min_q;
  logic signed [SAMPLE_W-1:0] max_q;
  logic        [LEN_W-1:0]    count_q;
  logic        [SPAN_W-1:0]   target_lat_q;
  logic        [GAIN_W-1:0]   max_gain_lat_q;
  logic signed [OFFSET_W-1:0] offset_q;
  logic        [GAIN_W-1:0]   gain_q;
  logic signed [SAMPLE_W-1:0] out_sample_q;
  logic                       out_end_q;
  logic        [GAIN_W-1:0]   out_gain_q;
  logic signed [OFFSET_W-1:0] out_offset_q;

  logic [SAMPLE_W-1:0] store_q [FRAME_MAX];

  // combinational signals
  logic              in_ready;
  logic              mem_re;
  logic              calc_go;
  logic              div_start;
  logic              div_busy;
  logic              div_done;
  logic [SUM_W-1:0]  div_a;
  logic [LEN_W-1:0]  div_b;
  logic [SUM_W-1:0]  div_quo;
  logic              mean_done;
  logic              gain_done;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  pos_inc;
  logic              last;
  logic              hold;
  logic              first;
  logic [PERIOD_W:0] phase_inc;
  logic [PERIOD_W:0] period;
  logic [SUM_W-1:0]  sum_abs;
  logic [LEN_W-1:0]  span;
  logic              span_zero;
  logic [SUM_W-1:0]  gain_cand;
  logic [GAIN_W-1:0] gain_clamp;
  logic [OFFSET_W-1:0] mean_mag;
  logic signed [OFFSET_W-1:0] offset_new;
  logic signed [SAMPLE_W+1:0] biased;
  logic signed [PROD_W-1:0]   prod;
  logic signed [SAMPLE_W-1:0] scaled;
  logic signed [SUM_W-1:0]    sample_ext;

  // frame length bounds and end of frame
  always_comb begin
    if (frame_length_q == '0) begin
      len = LEN_W'(1);
    end else if (LEN_W'(frame_length_q) > LEN_W'(FRAME_MAX)) begin
      len = LEN_W'(FRAME_MAX);
    end else begin
      len = LEN_W'(frame_length_q);
    end
    pos_inc   = LEN_W'(pos_q) + LEN_W'(1);
    last      = (pos_inc >= len);
    first     = (pos_q == '0);
    hold      = primed_q && out_valid_q && !out_o.ready;
    period    = (refresh_period_q == '0) ? (PERIOD_W+1)'(1)
                                         : {1'b0, refresh_period_q};
    phase_inc = {1'b0, phase_q} + (PERIOD_W+1)'(1);
  end

  // statistics seen by the divider
  always_comb begin
    sum_abs   = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
    span      = LEN_W'({max_q[SAMPLE_W-1], max_q} - {min_q[SAMPLE_W-1], min_q});
    span_zero = (span == '0);
  end

  // sequencer next state and strobes
  always_comb begin
    state_d   = state_q;
    in_ready  = 1'b0;
    mem_re    = 1'b0;
    calc_go   = 1'b0;
    div_start = 1'b0;
    div_a     = sum_abs;
    div_b     = count_q;
    mean_done = 1'b0;
    gain_done = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          mem_re  = 1'b1;
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        if (!hold) begin
          calc_go = 1'b1;
          state_d = (last && phase_q == '0) ? ST_MEAN_GO : ST_IDLE;
        end
      end
      ST_MEAN_GO: begin
        div_start = 1'b1;
        state_d   = ST_MEAN_RUN;
      end
      ST_MEAN_RUN: begin
        if (div_done) begin
          mean_done = 1'b1;
          if (span_zero) begin
            state_d = ST_IDLE;
          end else begin
            div_start = 1'b1;
            div_a     = SUM_W'(target_lat_q);
            div_b     = span;
            state_d   = ST_GAIN_RUN;
          end
        end
      end
      ST_GAIN_RUN: begin
        if (div_done) begin
          gain_done = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // shared divider for mean and gain
  fgon_div #(
    .DW (SUM_W),
    .VW (LEN_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // offset is the negated mean, gain clamped to 1..max_gain
  always_comb begin
    mean_mag   = OFFSET_W'(div_quo);
    offset_new = sum_q[SUM_W-1] ? $signed(mean_mag) : -$signed(mean_mag);
    gain_cand  = span_zero ? SUM_W'(max_gain_lat_q) : div_quo;
    gain_clamp = (gain_cand > SUM_W'(max_gain_lat_q)) ? max_gain_lat_q
                                                      : gain_cand[GAIN_W-1:0];
    if (gain_clamp == '0) begin
      gain_clamp = GAIN_W'(1);
    end
  end

  // scale the stored sample and saturate
  always_comb begin
    biased = (SAMPLE_W+2)'(rdata_q) + (SAMPLE_W+2)'(offset_q);
    prod   = PROD_W'(biased) * PROD_W'($signed({1'b0, gain_q}));
    if (prod > PROD_W'(32767)) begin
      scaled = 16'sh7fff;
    end else if (prod < -PROD_W'(32768)) begin
      scaled = 16'sh8000;
    end else begin
      scaled = prod[SAMPLE_W-1:0];
    end
    sample_ext = SUM_W'(sample_q);
  end

  // frame memory: read on accept, write back in ST_CALC
  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= store_q[pos_q];
    end
    if (calc_go) begin
      store_q[pos_q] <= sample_q;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_length_q   <= FRAME_LENGTH_RST;
      refresh_period_q <= REFRESH_PERIOD_RST;
      target_span_q    <= TARGET_SPAN_RST;
      max_gain_q       <= MAX_GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_LENGTH:   frame_length_q   <= cfg_data_i[FLEN_W-1:0];
        CFG_REFRESH_PERIOD: refresh_period_q <= cfg_data_i[PERIOD_W-1:0];
        CFG_TARGET_SPAN:    target_span_q    <= cfg_data_i[SPAN_W-1:0];
        CFG_MAX_GAIN:       max_gain_q       <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // frame position, refresh counter, output valid, offset and gain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      phase_q     <= '0;
      primed_q    <= 1'b0;
      out_valid_q <= 1'b0;
      offset_q    <= '0;
      gain_q      <= '0;
    end else begin
      if (calc_go && primed_q) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (calc_go) begin
        if (last) begin
          pos_q    <= '0;
          phase_q  <= (phase_inc >= period) ? '0 : phase_inc[PERIOD_W-1:0];
          primed_q <= 1'b1;
        end else begin
          pos_q <= pos_q + PW'(1);
        end
      end
      if (mean_done) begin
        offset_q <= offset_new;
      end
      if ((mean_done && span_zero) || gain_done) begin
        gain_q <= gain_clamp;
      end
    end
  end

  // sample latch, running statistics, latched divider operands and output payload
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      sample_q <= in_i.sample_in;
    end
    if (calc_go) begin
      if (first) begin
        sum_q <= sample_ext;
        min_q <= sample_q;
        max_q <= sample_q;
      end else begin
        sum_q <= sum_q + sample_ext;
        if (sample_q < min_q) begin
          min_q <= sample_q;
        end
        if (sample_q > max_q) begin
          max_q <= sample_q;
        end
      end
      if (last) begin
        count_q        <= pos_inc;
        target_lat_q   <= target_span_q;
        max_gain_lat_q <= max_gain_q;
      end
      if (primed_q) begin
        out_sample_q <= scaled;
        out_end_q    <= last;
        out_gain_q   <= gain_q;
        out_offset_q <= offset_q;
      end
    end
  end

  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid_q;
  assign out_o.sample_out  = out_sample_q;
  assign out_o.frame_end   = out_end_q;
  assign out_o.gain_used   = out_gain_q;
  assign out_o.offset_used = out_offset_q;

  // a waiting output beat is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (calc_go && primed_q) |-> (!out_valid_q || out_o.ready))
    else $error("output beat overwritten");

  // divider is started only when free
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  // once a frame is stored, an idle block holds a usable gain
  a_gain_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && primed_q) |-> (gain_q != '0))
    else $error("gain not refreshed after first frame");

  // an accepted sample moves on to the store stage
  a_accept_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q == ST_CALC))
    else $error("accepted sample not processed");

endmodule
